// ===== sv/fbpb_pkg.sv =====
// Shared types, codes and defaults for the framebuffer pixel blend engine.
package fbpb_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 16;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_BLEND = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_MIX,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// ===== sv/fbpb_if.sv =====
// Command and result channel interfaces of the pixel blend engine.
interface fbpb_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [fbpb_pkg::COORD_W-1:0] pos_x;
  logic signed [fbpb_pkg::COORD_W-1:0] pos_y;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic [7:0]  in_alpha;

  modport source (output valid, kind, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
                  input ready);
  modport sink   (input valid, kind, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
                  output ready);
endinterface

interface fbpb_res_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, ok, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, ok, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ===== sv/fbpb_pixel_mem.sv =====
// Single-port synchronous pixel memory with a registered read.
module fbpb_pixel_mem #(
  parameter int DEPTH = fbpb_pkg::MAX_WIDTH_DEF * fbpb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  fbpb_pkg::pixel_t                  wdata,
  output fbpb_pkg::pixel_t                  rdata
);

  fbpb_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/fbpb_blend.sv =====
// Source-over blend datapath: registered products, then sum and divide by 255.
module fbpb_blend (
  input  logic             clk,
  input  fbpb_pkg::pixel_t src,
  input  fbpb_pkg::pixel_t dst,
  output fbpb_pkg::pixel_t mixed
);

  logic [3:0][7:0] s_ch;
  logic [3:0][7:0] d_ch;
  logic [7:0]      inv_a;
  logic [15:0]     prod_s [4];
  logic [15:0]     prod_d [4];
  logic [3:0][7:0] m_ch;

  // alpha channel blends full scale over the stored alpha
  always_comb begin
    s_ch    = src;
    s_ch[3] = fbpb_pkg::FULL_SCALE;
    d_ch    = dst;
    inv_a   = fbpb_pkg::FULL_SCALE - src.alpha;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      prod_s[c] <= 16'(s_ch[c]) * 16'(src.alpha);
      prod_d[c] <= 16'(d_ch[c]) * 16'(inv_a);
    end
  end

  // floor(v / 255) == ((v + 1) * 257) >> 16 for v up to 255 * 255
  always_comb begin
    logic [16:0] sum;
    logic [16:0] t;
    logic [24:0] q;
    for (int c = 0; c < 4; c++) begin
      sum     = 17'(prod_s[c]) + 17'(prod_d[c]);
      t       = sum + 17'd1;
      q       = 25'(t) + (25'(t) << 8);
      m_ch[c] = q[23:16];
    end
  end

  assign mixed = m_ch;

endmodule

// ===== sv/framebuffer_pixel_blend_engine_top.sv =====
// Top level of the framebuffer pixel blend engine: sequencer, config and result register.
// A set or failed command runs decode, done; a blend runs decode, multiply, mix, done
// (read, multiply, mix and write back through the single memory port); a clear runs
// decode, the fill walk (one pixel written per cycle), done. Only idle takes a command.
// Reset: synchronous; frame size clears to 0, then a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT words before any command is taken.
module framebuffer_pixel_blend_engine_top #(
  parameter int MAX_WIDTH  = fbpb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fbpb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  fbpb_cmd_if.sink                       cmd,
  fbpb_res_if.source                     res,
  input  logic                           cfg_we,
  input  logic [fbpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int XW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = fbpb_pkg::CFG_W;
  localparam int LXW   = XW > CW ? XW : CW;
  localparam int LYW   = YW > CW ? YW : CW;
  localparam int CMAX  = (1 << CW) - 1;
  localparam logic [CW-1:0] W_CAP = CW'(MAX_WIDTH < CMAX ? MAX_WIDTH : CMAX);
  localparam logic [CW-1:0] H_CAP = CW'(MAX_HEIGHT < CMAX ? MAX_HEIGHT : CMAX);

  // configuration
  logic [CW-1:0] frame_width;
  logic [CW-1:0] frame_height;
  logic [CW-1:0] used_w;
  logic [CW-1:0] used_h;
  logic [CW-1:0] w_last;
  logic [CW-1:0] h_last;
  logic          empty;

  // sequencer
  fbpb_pkg::state_t state;
  fbpb_pkg::state_t state_next;

  // captured command word
  logic [1:0]                    c_kind;
  logic [fbpb_pkg::COORD_W-1:0]  c_x;
  logic [fbpb_pkg::COORD_W-1:0]  c_y;
  fbpb_pkg::pixel_t              c_color;

  // decode
  logic          x_ok;
  logic          y_ok;
  logic          pt_ok;
  logic          is_set;
  logic          is_blend;
  logic          is_clear;
  logic [AW-1:0] pt_addr;

  // clear walk and reset pass
  logic [XW-1:0] fill_x;
  logic [YW-1:0] fill_y;
  logic [AW-1:0] row_base;
  logic [AW-1:0] fill_addr;
  logic          fill_end_x;
  logic          fill_end_y;
  logic [AW-1:0] init_addr;
  logic          init_last;

  // memory port
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  fbpb_pkg::pixel_t mem_wdata;
  fbpb_pkg::pixel_t mem_rdata;
  fbpb_pkg::pixel_t blend_px;

  // pending result
  logic             p_ok;
  fbpb_pkg::pixel_t p_px;
  logic             out_load;

  // ---------------------------------------------------------------------------
  // Configuration registers; clamp the size to the store dimensions.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= '0;
      frame_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fbpb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        fbpb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign used_w = (frame_width > W_CAP) ? W_CAP : frame_width;
  assign used_h = (frame_height > H_CAP) ? H_CAP : frame_height;
  assign w_last = used_w - CW'(1);
  assign h_last = used_h - CW'(1);
  assign empty  = (used_w == '0) || (used_h == '0);

  // ---------------------------------------------------------------------------
  // Command capture: hold the word for the whole operation.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      c_kind          <= cmd.kind;
      c_x             <= cmd.pos_x;
      c_y             <= cmd.pos_y;
      c_color.red     <= cmd.in_red;
      c_color.green   <= cmd.in_green;
      c_color.blue    <= cmd.in_blue;
      c_color.alpha   <= cmd.in_alpha;
    end
  end

  // Point commands need non-negative coordinates inside the used rectangle.
  assign x_ok     = !c_x[fbpb_pkg::COORD_W-1]
                    && (c_x[fbpb_pkg::COORD_W-2:0] < (fbpb_pkg::COORD_W-1)'(used_w));
  assign y_ok     = !c_y[fbpb_pkg::COORD_W-1]
                    && (c_y[fbpb_pkg::COORD_W-2:0] < (fbpb_pkg::COORD_W-1)'(used_h));
  assign is_set   = (c_kind == fbpb_pkg::KIND_SET);
  assign is_blend = (c_kind == fbpb_pkg::KIND_BLEND);
  assign is_clear = (c_kind == fbpb_pkg::KIND_CLEAR) && !empty;
  assign pt_ok    = !empty && x_ok && y_ok && (is_set || is_blend);
  // row pitch is always MAX_WIDTH, so resizing never moves stored pixels
  assign pt_addr  = AW'(AW'(c_y[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(c_x[XW-1:0]);

  // ---------------------------------------------------------------------------
  // Clear walk: row base advances by the pitch, column counter wraps at w-1.
  // ---------------------------------------------------------------------------
  assign fill_addr  = row_base + AW'(fill_x);
  assign fill_end_x = (LXW'(fill_x) == LXW'(w_last));
  assign fill_end_y = (LYW'(fill_y) == LYW'(h_last));
  assign init_last  = (init_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
      fill_x    <= '0;
      fill_y    <= '0;
      row_base  <= '0;
    end else begin
      if (state == fbpb_pkg::ST_INIT) begin
        init_addr <= init_addr + AW'(1);
      end
      if (state == fbpb_pkg::ST_IDLE) begin
        fill_x   <= '0;
        fill_y   <= '0;
        row_base <= '0;
      end else if (state == fbpb_pkg::ST_FILL) begin
        if (fill_end_x) begin
          fill_x   <= '0;
          fill_y   <= fill_y + YW'(1);
          row_base <= row_base + AW'(MAX_WIDTH);
        end else begin
          fill_x <= fill_x + XW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbpb_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fbpb_pkg::ST_INIT: begin
        if (init_last) state_next = fbpb_pkg::ST_IDLE;
      end
      fbpb_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = fbpb_pkg::ST_DECODE;
      end
      fbpb_pkg::ST_DECODE: begin
        if (is_clear) begin
          state_next = fbpb_pkg::ST_FILL;
        end else if (pt_ok && is_blend) begin
          state_next = fbpb_pkg::ST_MUL;
        end else begin
          state_next = fbpb_pkg::ST_DONE;
        end
      end
      fbpb_pkg::ST_MUL:  state_next = fbpb_pkg::ST_MIX;
      fbpb_pkg::ST_MIX:  state_next = fbpb_pkg::ST_DONE;
      fbpb_pkg::ST_FILL: begin
        if (fill_end_x && fill_end_y) state_next = fbpb_pkg::ST_DONE;
      end
      fbpb_pkg::ST_DONE: begin
        if (out_load) state_next = fbpb_pkg::ST_IDLE;
      end
      default: state_next = fbpb_pkg::ST_INIT;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: memory port and input handshake.
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pt_addr;
    mem_wdata = c_color;
    cmd.ready = 1'b0;
    case (state)
      fbpb_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = init_addr;
        mem_wdata = '0;
      end
      fbpb_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      fbpb_pkg::ST_DECODE: begin
        // blend reads the destination; set writes straight away
        mem_re = pt_ok && is_blend;
        mem_we = pt_ok && is_set;
      end
      fbpb_pkg::ST_MIX: begin
        mem_we    = 1'b1;
        mem_wdata = blend_px;
      end
      fbpb_pkg::ST_FILL: begin
        mem_we   = 1'b1;
        mem_addr = fill_addr;
      end
      default: ;
    endcase
  end

  fbpb_pixel_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fbpb_blend u_blend (
    .clk   (clk),
    .src   (c_color),
    .dst   (mem_rdata),
    .mixed (blend_px)
  );

  // ---------------------------------------------------------------------------
  // Pending result: a failed command reports zero pixel.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      fbpb_pkg::ST_DECODE: begin
        if (!is_clear) begin
          p_ok <= pt_ok;
          p_px <= pt_ok ? c_color : '0;
        end
      end
      fbpb_pkg::ST_MIX: begin
        p_ok <= 1'b1;
        p_px <= blend_px;
      end
      fbpb_pkg::ST_FILL: begin
        p_ok <= 1'b1;
        p_px <= c_color;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: load when empty or being drained.
  // ---------------------------------------------------------------------------
  assign out_load = (state == fbpb_pkg::ST_DONE) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.ok        <= p_ok;
      res.out_red   <= p_px.red;
      res.out_green <= p_px.green;
      res.out_blue  <= p_px.blue;
      res.out_alpha <= p_px.alpha;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ok) |-> (res.out_red == 8'd0) && (res.out_green == 8'd0)
                               && (res.out_blue == 8'd0) && (res.out_alpha == 8'd0))
    else $error("failed command reported a nonzero pixel");

  a_read_then_mix: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> (state == fbpb_pkg::ST_MUL) ##1 (state == fbpb_pkg::ST_MIX))
    else $error("destination read not followed by multiply and write back");

  a_fill_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == fbpb_pkg::ST_FILL) |-> (LXW'(fill_x) <= LXW'(w_last))
                                      && (LYW'(fill_y) <= LYW'(h_last)) && !empty)
    else $error("clear walk left the frame");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == fbpb_pkg::ST_DONE))
    else $error("result word loaded outside the done state");

endmodule

// ===== tb/sv/tb_framebuffer_pixel_blend_engine_top.sv =====
// Self-checking testbench for the framebuffer pixel blend engine top level.
module tb_framebuffer_pixel_blend_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD = 10;
  localparam int unsigned FB_W       = fbpb_pkg::MAX_WIDTH_DEF;
  localparam int unsigned FB_H       = fbpb_pkg::MAX_HEIGHT_DEF;
  // Largest frame area for which random traffic may issue a clear.
  localparam int unsigned CLEAR_AREA_MAX = 2048;
  // Kind code that the engine must refuse.
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  // Must cover the reset clearing pass, one full-frame clear and ~1500 words with worst-case
  // gaps and stalls, with a wide margin.
  localparam longint      RUN_LIMIT_NS = 64'd3_000_000 * CLK_PERIOD;

  // One command word as it goes over the command channel.
  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    fbpb_pkg::pixel_t    colour;
  } cmd_word_t;

  // One result word: status plus the pixel that was written.
  typedef struct packed {
    logic             ok;
    fbpb_pkg::pixel_t px;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [fbpb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fbpb_pkg::CFG_W-1:0]     cfg_data;

  fbpb_cmd_if cmd_ch ();
  fbpb_res_if res_ch ();

  framebuffer_pixel_blend_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the pixel store and of the two size registers.
  fbpb_pkg::pixel_t           shadow_fb [FB_W * FB_H];
  logic [fbpb_pkg::CFG_W-1:0] frame_w;
  logic [fbpb_pkg::CFG_W-1:0] frame_h;

  // Result words the engine still owes us, oldest first.
  pixel_result_t   owed_results [$];

  // Idling knobs: gaps on the command side, stalls on the result side.
  bit              cmd_gaps_on   = 1'b1;
  bit              res_stalls_on = 1'b1;

  int unsigned     err_count;
  int unsigned     n_sent;
  int unsigned     n_took_effect;
  int unsigned     n_checked;
  int unsigned     n_sizes;

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= 200) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Size registers above the store size clamp to the store size.
  function automatic int unsigned used_w();
    return (frame_w > FB_W) ? FB_W : int'(frame_w);
  endfunction

  function automatic int unsigned used_h();
    return (frame_h > FB_H) ? FB_H : int'(frame_h);
  endfunction

  // Source-over on one channel, truncating division.
  function automatic logic [7:0] mix_chan(int unsigned s, int unsigned a, int unsigned d);
    return 8'((s * a + d * (fbpb_pkg::FULL_SCALE - a)) / fbpb_pkg::FULL_SCALE);
  endfunction

  // Apply one command to the shadow store and return the result word it owes.
  function automatic pixel_result_t predict_pixel_cmd(cmd_word_t c);
    pixel_result_t    r;
    fbpb_pkg::pixel_t d;
    int unsigned      uw;
    int unsigned      uh;
    int unsigned      addr;
    r  = '0;
    uw = used_w();
    uh = used_h();
    // Empty frame: nothing takes effect.
    if (uw == 0 || uh == 0) return r;
    if (c.kind == fbpb_pkg::KIND_CLEAR) begin
      for (int unsigned y = 0; y < uh; y++)
        for (int unsigned x = 0; x < uw; x++)
          shadow_fb[y * FB_W + x] = c.colour;
      r.ok = 1'b1;
      r.px = c.colour;
      return r;
    end
    // Refuse unused kinds, negative coordinates and anything past the frame edge.
    if (c.kind == KIND_UNUSED || c.pos_x[15] || c.pos_y[15]) return r;
    if (int'(c.pos_x) >= uw || int'(c.pos_y) >= uh) return r;
    addr = int'(c.pos_y) * FB_W + int'(c.pos_x);
    if (c.kind == fbpb_pkg::KIND_SET) begin
      r.px = c.colour;
    end else begin
      d          = shadow_fb[addr];
      r.px.red   = mix_chan(c.colour.red,   c.colour.alpha, d.red);
      r.px.green = mix_chan(c.colour.green, c.colour.alpha, d.green);
      r.px.blue  = mix_chan(c.colour.blue,  c.colour.alpha, d.blue);
      r.px.alpha = mix_chan(fbpb_pkg::FULL_SCALE, c.colour.alpha, d.alpha);
    end
    shadow_fb[addr] = r.px;
    r.ok = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  function automatic cmd_word_t mk_cmd(logic [1:0] kind, int x, int y,
                                       int unsigned r, int unsigned g,
                                       int unsigned b, int unsigned a);
    cmd_word_t c;
    c.kind         = kind;
    c.pos_x        = 16'(x);
    c.pos_y        = 16'(y);
    c.colour.red   = 8'(r);
    c.colour.green = 8'(g);
    c.colour.blue  = 8'(b);
    c.colour.alpha = 8'(a);
    return c;
  endfunction

  // Send one command word. Valid is left high on return so that a following
  // word goes out back to back; settle_engine drops it when a phase ends.
  task automatic send_cmd(cmd_word_t c);
    pixel_result_t due;
    if (cmd_gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.kind     <= c.kind;
    cmd_ch.pos_x    <= c.pos_x;
    cmd_ch.pos_y    <= c.pos_y;
    cmd_ch.in_red   <= c.colour.red;
    cmd_ch.in_green <= c.colour.green;
    cmd_ch.in_blue  <= c.colour.blue;
    cmd_ch.in_alpha <= c.colour.alpha;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    // Accepted at this edge: predict now, before any result can come back.
    due = predict_pixel_cmd(c);
    owed_results.push_back(due);
    n_sent++;
    if (due.ok) n_took_effect++;
  endtask

  // Drop valid, wait until every owed word has come back, then let the engine
  // finish its write-back before anything touches the size registers.
  task automatic settle_engine();
    cmd_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both size registers on back-to-back edges while the engine is idle.
  task automatic resize_frame(int unsigned w, int unsigned h);
    settle_engine();
    cfg_we    <= 1'b1;
    cfg_index <= fbpb_pkg::REG_FRAME_WIDTH;
    cfg_data  <= (fbpb_pkg::CFG_W)'(w);
    @(posedge clk);
    cfg_index <= fbpb_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= (fbpb_pkg::CFG_W)'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_w = (fbpb_pkg::CFG_W)'(w);
    frame_h = (fbpb_pkg::CFG_W)'(h);
    n_sizes++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Hold ready low in random bursts, with long stretches of no stall between.
  initial begin
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (res_stalls_on && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Compare every accepted result word against the oldest owed one.
  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      n_checked++;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing owed: ok=%b px=%02h%02h%02h%02h",
                                  res_ch.ok, res_ch.out_alpha, res_ch.out_blue,
                                  res_ch.out_green, res_ch.out_red));
      end else begin
        want = owed_results.pop_front();
        if (res_ch.ok !== want.ok || res_ch.out_red !== want.px.red ||
            res_ch.out_green !== want.px.green || res_ch.out_blue !== want.px.blue ||
            res_ch.out_alpha !== want.px.alpha) begin
          report_mismatch($sformatf(
            "word %0d: ok/r/g/b/a got %b/%02h/%02h/%02h/%02h want %b/%02h/%02h/%02h/%02h",
            n_checked, res_ch.ok, res_ch.out_red, res_ch.out_green, res_ch.out_blue,
            res_ch.out_alpha, want.ok, want.px.red, want.px.green, want.px.blue,
            want.px.alpha));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random traffic helpers
  // ---------------------------------------------------------------------------

  // Mostly inside the frame, sometimes just past the edge, at -1, or anywhere.
  function automatic int pick_coord(int unsigned span);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode <= 6 && span != 0) return $urandom_range(0, span - 1);
    if (mode == 7) return span;
    if (mode == 8) return -1;
    return $urandom_range(0, 65535);
  endfunction

  // Alpha at both ends often, so the pure-dest and pure-source cases show up.
  function automatic int unsigned pick_alpha();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic cmd_word_t random_cmd();
    int unsigned sel;
    logic [1:0]  kind;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // Pure noise: any kind, any coordinate.
      return mk_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
    end
    if (sel < 48)      kind = fbpb_pkg::KIND_SET;
    else if (sel < 90) kind = fbpb_pkg::KIND_BLEND;
    else if (sel < 96) kind = (used_w() * used_h() <= CLEAR_AREA_MAX) ?
                              fbpb_pkg::KIND_CLEAR : fbpb_pkg::KIND_BLEND;
    else               kind = KIND_UNUSED;
    return mk_cmd(kind, pick_coord(used_w()), pick_coord(used_h()),
                  $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), pick_alpha());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the frame is empty: every kind must be refused.
  task automatic test_empty_frame();
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   0, 0, 8'h11, 8'h22, 8'h33, 8'h44));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 0, 0, 8'h11, 8'h22, 8'h33, 8'h80));
    send_cmd(mk_cmd(fbpb_pkg::KIND_CLEAR, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff));
    send_cmd(mk_cmd(KIND_UNUSED,          0, 0, 8'h01, 8'h02, 8'h03, 8'h04));
    // Only one dimension zero is still an empty frame.
    resize_frame(5, 0);
    send_cmd(mk_cmd(fbpb_pkg::KIND_CLEAR, 0, 0, 8'haa, 8'hbb, 8'hcc, 8'hdd));
    resize_frame(0, 5);
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   1, 1, 8'haa, 8'hbb, 8'hcc, 8'hdd));
  endtask

  // Full-size frame: corners, alpha extremes, coordinate extremes, one full clear.
  task automatic test_frame_extremes();
    resize_frame(FB_W, FB_H);
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   0,   0,   8'hff, 8'hff, 8'hff, 8'hff));
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   255, 255, 8'h01, 8'h80, 8'hfe, 8'h7f));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 255, 255, 8'hff, 8'h00, 8'h55, 8'h00));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 255, 255, 8'h12, 8'h34, 8'h56, 8'hff));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 0,   0,   8'h00, 8'h40, 8'hc0, 8'h80));
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   256, 0,   8'h01, 8'h01, 8'h01, 8'h01));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 0,   256, 8'h01, 8'h01, 8'h01, 8'h01));
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   -1,  0,   8'h01, 8'h01, 8'h01, 8'h01));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 0,   -32768, 8'h01, 8'h01, 8'h01, 8'h01));
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   32767, 32767, 8'h01, 8'h01, 8'h01, 8'h01));
    send_cmd(mk_cmd(KIND_UNUSED,          1,   1,   8'hff, 8'hff, 8'hff, 8'hff));
    send_cmd(mk_cmd(fbpb_pkg::KIND_CLEAR, 0,   0,   8'h12, 8'h34, 8'h56, 8'h78));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 128, 128, 8'hf0, 8'h0f, 8'h99, 8'hc8));
  endtask

  // Oversized registers clamp; resizing leaves stored pixels where they are.
  task automatic test_resize_keeps_pixels();
    resize_frame(511, 300);
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   255, 255, 8'h5a, 8'ha5, 8'h3c, 8'hc3));
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   256, 0,   8'h5a, 8'ha5, 8'h3c, 8'hc3));
    send_cmd(mk_cmd(fbpb_pkg::KIND_SET,   3,   2,   8'h20, 8'h40, 8'h60, 8'h80));
    resize_frame(4, 3);
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 3,   2,   8'hff, 8'hff, 8'hff, 8'h40));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 4,   2,   8'hff, 8'hff, 8'hff, 8'h40));
    resize_frame(2, 2);
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 3,   2,   8'hff, 8'hff, 8'hff, 8'h40));
    send_cmd(mk_cmd(fbpb_pkg::KIND_CLEAR, 0,   0,   8'h0a, 8'h0b, 8'h0c, 8'h0d));
    // Pixel (3,2) lies outside the 2x2 clear and must keep its blended value.
    resize_frame(8, 8);
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 3,   2,   8'h00, 8'h00, 8'h00, 8'h10));
    send_cmd(mk_cmd(fbpb_pkg::KIND_BLEND, 1,   1,   8'h80, 8'h80, 8'h80, 8'h80));
  endtask

  // Random phases, each at a new frame size. The last phases run without idling.
  task automatic test_random_traffic();
    int unsigned w;
    int unsigned h;
    for (int p = 0; p < 16; p++) begin
      case (p)
        3:       begin w = 1;                          h = 1;                        end
        5:       begin w = FB_W;                       h = $urandom_range(1, 4);     end
        7:       begin w = $urandom_range(1, 4);       h = FB_H;                     end
        9:       begin w = 0;                          h = $urandom_range(0, 16);    end
        11:      begin w = $urandom_range(257, 511);   h = $urandom_range(1, 8);     end
        default: begin w = $urandom_range(1, 16);      h = $urandom_range(1, 16);    end
      endcase
      if (p >= 12) begin
        cmd_gaps_on   = 1'b0;
        res_stalls_on = 1'b0;
      end
      resize_frame(w, h);
      repeat (95) send_cmd(random_cmd());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    frame_w = '0;
    frame_h = '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.kind     <= fbpb_pkg::KIND_SET;
    cmd_ch.pos_x    <= '0;
    cmd_ch.pos_y    <= '0;
    cmd_ch.in_red   <= '0;
    cmd_ch.in_green <= '0;
    cmd_ch.in_blue  <= '0;
    cmd_ch.in_alpha <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= fbpb_pkg::REG_FRAME_WIDTH;
    cfg_data        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // The engine walks its whole store after reset; send_cmd waits on ready.
    test_empty_frame();
    test_frame_extremes();
    test_resize_keeps_pixels();
    test_random_traffic();
    settle_engine();
    repeat (8) @(posedge clk);
    $display("Covered %0d commands (%0d took effect, the rest refused) at %0d frame sizes,",
             n_sent, n_took_effect, n_sizes);
    $display("including empty, clamped and full-size frames; %0d result words checked.",
             n_checked);
    if (err_count == 0) begin
      $display("tb_framebuffer_pixel_blend_engine_top OK");
    end else begin
      $display("tb_framebuffer_pixel_blend_engine_top NOT OK");
    end
    $finish;
  end

  // Hard stop if the engine hangs on either channel.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d result words still owed", owed_results.size());
    $display("tb_framebuffer_pixel_blend_engine_top NOT OK");
    $finish;
  end

endmodule
